### hdl/lst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_pkg: shared types and constants of the lazy segment tree
// Field widths, register indexes, command and status groups between the
// controller and the datapath, and the select codes they carry.
// ----------------------------------------------------------------------------
package lst_pkg;

	localparam int MAX_POSITIONS_DEF = 1024;
	localparam int IDX_W             = 11;
	localparam int VAL_W             = 31;
	localparam int CFG_IDX_W         = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_COUNT = 1'b1;

	localparam logic [VAL_W-1:0] MODULUS_RST   = 31'h7FFF_FFFF;
	localparam logic [IDX_W-1:0] POS_COUNT_RST = 11'd1024;

	// modular unit operations
	localparam logic AR_RED = 1'b0;
	localparam logic AR_MUL = 1'b1;

	// modular unit operand sources
	localparam logic [1:0] SRC_VRAW = 2'd0;
	localparam logic [1:0] SRC_SUM  = 2'd1;
	localparam logic [1:0] SRC_PEND = 2'd2;
	localparam logic [1:0] SRC_TAG  = 2'd3;

	// node store read address sources
	localparam logic [1:0] RA_CUR   = 2'd0;
	localparam logic [1:0] RA_LEFT  = 2'd1;
	localparam logic [1:0] RA_RIGHT = 2'd2;
	localparam logic [1:0] RA_TGT   = 2'd3;

	// frames pushed on the traversal stack
	localparam logic [1:0] PS_ROOT  = 2'd0;
	localparam logic [1:0] PS_SELF  = 2'd1;
	localparam logic [1:0] PS_RIGHT = 2'd2;
	localparam logic [1:0] PS_LEFT  = 2'd3;

	// node that receives a tag
	localparam logic [1:0] TG_CUR   = 2'd0;
	localparam logic [1:0] TG_LEFT  = 2'd1;
	localparam logic [1:0] TG_RIGHT = 2'd2;

	typedef struct packed {
		logic       clr;
		logic       load;
		logic       push;
		logic [1:0] push_sel;
		logic       pop;
		logic       rd;
		logic [1:0] rd_sel;
		logic       ar_start;
		logic       ar_op;
		logic [1:0] ar_src;
		logic       cap_vred;
		logic       cap_a;
		logic       cap_b;
		logic       tag_v;
		logic       tag_res;
		logic       tgt_load;
		logic [1:0] tgt_sel;
		logic       acc_add;
		logic       wr_tag;
		logic       wr_pull;
		logic       wr_pz;
		logic       out_load;
	} lst_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic is_sum;
		logic sp_zero;
		logic post;
		logic covered;
		logic go_left;
		logic go_right;
		logic pend_zero;
		logic ar_done;
		logic out_free;
	} lst_sts_t;

endpackage

### hdl/lst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_if: request and result channels
// Valid/ready channels carrying one command request and one range sum.
// ----------------------------------------------------------------------------
interface lst_req_if;
	import lst_pkg::*;
	logic             valid;
	logic             ready;
	logic             command;
	logic [IDX_W-1:0] left_index;
	logic [IDX_W-1:0] right_index;
	logic [VAL_W-1:0] addend;

	modport source (output valid, command, left_index, right_index, addend, input ready);
	modport sink (input valid, command, left_index, right_index, addend, output ready);
endinterface

interface lst_res_if;
	import lst_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink (input valid, range_sum, output ready);
endinterface

### hdl/lst_modu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_modu: serial modular reduce and multiply unit
// Reduces a value modulo the modulus one bit a cycle, or multiplies a
// reduced value by a segment length with a shift-add, one length bit a cycle.
// ----------------------------------------------------------------------------
module lst_modu #(
	parameter int LEN_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    op,
	input  logic [lst_pkg::VAL_W-1:0] x,
	input  logic [LEN_W-1:0]        len,
	input  logic [lst_pkg::VAL_W:0]   modulus,
	output logic                    done,
	output logic [lst_pkg::VAL_W-1:0] res
);
	import lst_pkg::*;

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             op_q;
	logic [VAL_W:0]   acc_q;
	logic [VAL_W-1:0] sh_q;
	logic [VAL_W-1:0] a_q;
	logic [CNT_W-1:0] cnt_q;

	logic [VAL_W+1:0] dbl;
	logic [VAL_W+1:0] addv;
	logic [VAL_W+1:0] sum_t;
	logic [VAL_W+1:0] p1;
	logic [VAL_W+1:0] p2;
	logic [VAL_W+1:0] nxt;

	// 2*acc + next term stays below three moduli; pick the fitting subtraction
	always_comb begin
		dbl   = {acc_q, 1'b0};
		if (op_q == AR_MUL) begin
			addv = sh_q[VAL_W-1] ? {2'b00, a_q} : '0;
		end else begin
			addv = {{(VAL_W+1){1'b0}}, sh_q[VAL_W-1]};
		end
		sum_t = dbl + addv;
		p1    = {1'b0, modulus};
		p2    = {modulus, 1'b0};
		if (sum_t >= p2) begin
			nxt = sum_t - p2;
		end else if (sum_t >= p1) begin
			nxt = sum_t - p1;
		end else begin
			nxt = sum_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				if (op == AR_RED && {1'b0, x} < modulus) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			op_q <= op;
			a_q  <= x;
			if (op == AR_RED && {1'b0, x} < modulus) begin
				acc_q <= {1'b0, x};
			end else begin
				acc_q <= '0;
			end
			if (op == AR_MUL) begin
				sh_q  <= {len, {(VAL_W-LEN_W){1'b0}}};
				cnt_q <= CNT_W'(LEN_W);
			end else begin
				sh_q  <= x;
				cnt_q <= CNT_W'(VAL_W);
			end
		end else if (busy_q) begin
			acc_q <= nxt[VAL_W:0];
			sh_q  <= {sh_q[VAL_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign res  = acc_q[VAL_W-1:0];

endmodule

### hdl/lst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_dp: datapath of the lazy segment tree
// Configuration registers, request latch, traversal stack, node sum and
// pending tag stores, modular arithmetic and the result register.
// ----------------------------------------------------------------------------
module lst_dp #(
	parameter int MAX_POSITIONS = lst_pkg::MAX_POSITIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lst_pkg::lst_cmd_t             cmd,
	output lst_pkg::lst_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [lst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lst_pkg::VAL_W-1:0]     cfg_data,
	input  logic                          command,
	input  logic [lst_pkg::IDX_W-1:0]     left_index,
	input  logic [lst_pkg::IDX_W-1:0]     right_index,
	input  logic [lst_pkg::VAL_W-1:0]     addend,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [lst_pkg::VAL_W-1:0]     out_sum
);
	import lst_pkg::*;

	localparam int PW    = $clog2(MAX_POSITIONS + 1);
	localparam int NW    = $clog2(MAX_POSITIONS) + 1;
	localparam int DEPTH = 1 << NW;
	localparam int SD    = 2 * NW + 2;
	localparam int SIW   = $clog2(SD);
	localparam int SPW   = $clog2(SD + 1);
	localparam int LW    = (PW > IDX_W) ? PW : IDX_W;

	function automatic logic [VAL_W-1:0] addmod(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b, input logic [VAL_W:0] m);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= m) begin
			s = s - m;
		end
		return s[VAL_W-1:0];
	endfunction

	// configuration
	logic [VAL_W-1:0] mod_q;
	logic [IDX_W-1:0] pc_q;
	logic [VAL_W:0]   pmod;

	// request
	logic             cmd_q;
	logic             empty_q;
	logic [PW-1:0]    s_q;
	logic [PW-1:0]    t_q;
	logic [PW-1:0]    n_q;
	logic [VAL_W-1:0] vraw_q;
	logic [LW-1:0]    pcx, nx, sx, tx, rx;

	// arithmetic
	logic [VAL_W-1:0] vred_q, a_q, b_q, tag_q, acc_q;
	logic [VAL_W-1:0] ar_x, ar_res;
	logic             ar_done;

	// stack and current frame
	logic [NW-1:0]    stk_u    [SD];
	logic [PW-1:0]    stk_lo   [SD];
	logic [PW-1:0]    stk_hi   [SD];
	logic             stk_post [SD];
	logic [SPW-1:0]   sp_q;
	logic [SPW-1:0]   spm1;
	logic [NW-1:0]    cu_q;
	logic [PW-1:0]    clo_q, chi_q;
	logic             cpost_q;
	logic [PW:0]      msum;
	logic [PW-1:0]    mid, mid1;
	logic [NW-1:0]    lc, rc;
	logic [NW-1:0]    pu;
	logic [PW-1:0]    plo, phi;
	logic             ppost;

	// tag target
	logic [NW-1:0]    tn_q;
	logic [PW-1:0]    tlo_q, thi_q;
	logic [PW-1:0]    len;

	// node store
	logic [VAL_W-1:0] sum_mem  [DEPTH];
	logic [VAL_W-1:0] pend_mem [DEPTH];
	logic [VAL_W-1:0] rd_sum_q, rd_pend_q;
	logic [NW-1:0]    ra;
	logic [NW-1:0]    clr_q;
	logic             sum_we, pend_we;
	logic [NW-1:0]    sum_wa, pend_wa;
	logic [VAL_W-1:0] sum_wd, pend_wd;

	// result
	logic             out_valid_q;
	logic [VAL_W-1:0] out_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RST;
			pc_q  <= POS_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:   mod_q <= cfg_data;
				REG_POS_COUNT: pc_q  <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero modulus stands for two to the width
	assign pmod = (mod_q == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, mod_q};

	always_comb begin
		pcx = LW'(pc_q);
		if (pcx == '0) begin
			nx = LW'(1);
		end else if (pcx > LW'(MAX_POSITIONS)) begin
			nx = LW'(MAX_POSITIONS);
		end else begin
			nx = pcx;
		end
		sx = (LW'(left_index) == '0) ? LW'(1) : LW'(left_index);
		rx = LW'(right_index);
		tx = (rx > nx) ? nx : rx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.load) begin
			cmd_q   <= command;
			empty_q <= (sx > tx);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q    <= sx[PW-1:0];
			t_q    <= tx[PW-1:0];
			n_q    <= nx[PW-1:0];
			vraw_q <= addend;
		end
	end

	// current frame geometry
	always_comb begin
		msum = {1'b0, clo_q} + {1'b0, chi_q};
		mid  = msum[PW:1];
		mid1 = mid + 1'b1;
		lc   = {cu_q[NW-2:0], 1'b0};
		rc   = {cu_q[NW-2:0], 1'b1};
		spm1 = sp_q - 1'b1;
		case (cmd.push_sel)
			PS_ROOT: begin
				pu = NW'(1); plo = PW'(1); phi = n_q; ppost = 1'b0;
			end
			PS_SELF: begin
				pu = cu_q; plo = clo_q; phi = chi_q; ppost = 1'b1;
			end
			PS_RIGHT: begin
				pu = rc; plo = mid1; phi = chi_q; ppost = 1'b0;
			end
			default: begin
				pu = lc; plo = clo_q; phi = mid; ppost = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + 1'b1;
		end else if (cmd.pop) begin
			sp_q <= spm1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_u[sp_q[SIW-1:0]]    <= pu;
			stk_lo[sp_q[SIW-1:0]]   <= plo;
			stk_hi[sp_q[SIW-1:0]]   <= phi;
			stk_post[sp_q[SIW-1:0]] <= ppost;
		end
		if (cmd.pop) begin
			cu_q    <= stk_u[spm1[SIW-1:0]];
			clo_q   <= stk_lo[spm1[SIW-1:0]];
			chi_q   <= stk_hi[spm1[SIW-1:0]];
			cpost_q <= stk_post[spm1[SIW-1:0]];
		end
		if (cmd.tgt_load) begin
			case (cmd.tgt_sel)
				TG_LEFT: begin
					tn_q <= lc; tlo_q <= clo_q; thi_q <= mid;
				end
				TG_RIGHT: begin
					tn_q <= rc; tlo_q <= mid1; thi_q <= chi_q;
				end
				default: begin
					tn_q <= cu_q; tlo_q <= clo_q; thi_q <= chi_q;
				end
			endcase
		end
	end

	assign len = thi_q - tlo_q + 1'b1;

	always_comb begin
		case (cmd.ar_src)
			SRC_VRAW: ar_x = vraw_q;
			SRC_SUM:  ar_x = rd_sum_q;
			SRC_PEND: ar_x = rd_pend_q;
			default:  ar_x = tag_q;
		endcase
	end

	lst_modu #(
		.LEN_W (PW)
	) u_modu (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.ar_start),
		.op      (cmd.ar_op),
		.x       (ar_x),
		.len     (len),
		.modulus (pmod),
		.done    (ar_done),
		.res     (ar_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= addmod(acc_q, ar_res, pmod);
		end
		if (cmd.cap_vred) begin
			vred_q <= ar_res;
		end
		if (cmd.cap_a) begin
			a_q <= ar_res;
		end
		if (cmd.cap_b) begin
			b_q <= ar_res;
		end
		if (cmd.tag_v) begin
			tag_q <= vred_q;
		end else if (cmd.tag_res) begin
			tag_q <= ar_res;
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RA_CUR:   ra = cu_q;
			RA_LEFT:  ra = lc;
			RA_RIGHT: ra = rc;
			default:  ra = tn_q;
		endcase
		sum_we  = cmd.clr | cmd.wr_tag | cmd.wr_pull;
		pend_we = cmd.clr | cmd.wr_tag | cmd.wr_pz;
		if (cmd.clr) begin
			sum_wa = clr_q;
			sum_wd = '0;
		end else if (cmd.wr_tag) begin
			sum_wa = tn_q;
			sum_wd = addmod(a_q, ar_res, pmod);
		end else begin
			sum_wa = cu_q;
			sum_wd = addmod(a_q, ar_res, pmod);
		end
		if (cmd.clr) begin
			pend_wa = clr_q;
			pend_wd = '0;
		end else if (cmd.wr_tag) begin
			pend_wa = tn_q;
			pend_wd = addmod(b_q, tag_q, pmod);
		end else begin
			pend_wa = cu_q;
			pend_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		if (cmd.rd) begin
			rd_sum_q <= sum_mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_wa] <= pend_wd;
		end
		if (cmd.rd) begin
			rd_pend_q <= pend_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sum_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;

	always_comb begin
		sts.clr_last  = &clr_q;
		sts.empty     = empty_q;
		sts.is_sum    = cmd_q;
		sts.sp_zero   = (sp_q == '0);
		sts.post      = cpost_q;
		sts.covered   = (s_q <= clo_q) && (chi_q <= t_q);
		sts.go_left   = (s_q <= mid);
		sts.go_right  = (t_q > mid);
		sts.pend_zero = (rd_pend_q == '0);
		sts.ar_done   = ar_done;
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

### hdl/lst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_ctrl: traversal controller
// Sweeps the node store clear, then walks the tree for each request with an
// explicit stack: push down tags, apply tags, pull up sums, gather sums.
// ----------------------------------------------------------------------------
module lst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              ready,
	input  lst_pkg::lst_sts_t sts,
	output lst_pkg::lst_cmd_t cmd
);
	import lst_pkg::*;

	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_SETUP  = 5'd2;
	localparam logic [4:0] S_VRED   = 5'd3;
	localparam logic [4:0] S_POP    = 5'd4;
	localparam logic [4:0] S_DECIDE = 5'd5;
	localparam logic [4:0] S_PU1    = 5'd6;
	localparam logic [4:0] S_PU2    = 5'd7;
	localparam logic [4:0] S_PU3    = 5'd8;
	localparam logic [4:0] S_PU4    = 5'd9;
	localparam logic [4:0] S_QS1    = 5'd10;
	localparam logic [4:0] S_QS2    = 5'd11;
	localparam logic [4:0] S_PD1    = 5'd12;
	localparam logic [4:0] S_PD2    = 5'd13;
	localparam logic [4:0] S_AT_RD  = 5'd14;
	localparam logic [4:0] S_AT1    = 5'd15;
	localparam logic [4:0] S_AT2    = 5'd16;
	localparam logic [4:0] S_AT3    = 5'd17;
	localparam logic [4:0] S_AT4    = 5'd18;
	localparam logic [4:0] S_PDZ    = 5'd19;
	localparam logic [4:0] S_PUSHS  = 5'd20;
	localparam logic [4:0] S_PUSHR  = 5'd21;
	localparam logic [4:0] S_PUSHL  = 5'd22;
	localparam logic [4:0] S_OUT    = 5'd23;

	// where to go once a tag is applied
	localparam logic [1:0] RET_POP = 2'd0;
	localparam logic [1:0] RET_PDL = 2'd1;
	localparam logic [1:0] RET_PDR = 2'd2;

	logic [4:0] state_q, state_d;
	logic [1:0] ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= RET_POP;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				if (sts.empty) begin
					state_d = sts.is_sum ? S_OUT : S_IDLE;
				end else begin
					cmd.push     = 1'b1;
					cmd.push_sel = PS_ROOT;
					if (sts.is_sum) begin
						state_d = S_POP;
					end else begin
						cmd.ar_start = 1'b1;
						cmd.ar_op    = AR_RED;
						cmd.ar_src   = SRC_VRAW;
						state_d      = S_VRED;
					end
				end
			end
			S_VRED: begin
				if (sts.ar_done) begin
					cmd.cap_vred = 1'b1;
					state_d      = S_POP;
				end
			end
			S_POP: begin
				if (sts.sp_zero) begin
					state_d = sts.is_sum ? S_OUT : S_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.post) begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = RA_LEFT;
					state_d    = S_PU1;
				end else if (sts.covered) begin
					if (sts.is_sum) begin
						cmd.rd     = 1'b1;
						cmd.rd_sel = RA_CUR;
						state_d    = S_QS1;
					end else begin
						cmd.tgt_load = 1'b1;
						cmd.tgt_sel  = TG_CUR;
						cmd.tag_v    = 1'b1;
						ret_d        = RET_POP;
						state_d      = S_AT_RD;
					end
				end else begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = RA_CUR;
					state_d    = S_PD1;
				end
			end
			S_PU1: begin
				cmd.ar_start = 1'b1;
				cmd.ar_op    = AR_RED;
				cmd.ar_src   = SRC_SUM;
				state_d      = S_PU2;
			end
			S_PU2: begin
				if (sts.ar_done) begin
					cmd.cap_a  = 1'b1;
					cmd.rd     = 1'b1;
					cmd.rd_sel = RA_RIGHT;
					state_d    = S_PU3;
				end
			end
			S_PU3: begin
				cmd.ar_start = 1'b1;
				cmd.ar_op    = AR_RED;
				cmd.ar_src   = SRC_SUM;
				state_d      = S_PU4;
			end
			S_PU4: begin
				if (sts.ar_done) begin
					cmd.wr_pull = 1'b1;
					state_d     = S_POP;
				end
			end
			S_QS1: begin
				cmd.ar_start = 1'b1;
				cmd.ar_op    = AR_RED;
				cmd.ar_src   = SRC_SUM;
				state_d      = S_QS2;
			end
			S_QS2: begin
				if (sts.ar_done) begin
					cmd.acc_add = 1'b1;
					state_d     = S_POP;
				end
			end
			S_PD1: begin
				if (sts.pend_zero) begin
					state_d = S_PUSHS;
				end else begin
					cmd.ar_start = 1'b1;
					cmd.ar_op    = AR_RED;
					cmd.ar_src   = SRC_PEND;
					state_d      = S_PD2;
				end
			end
			S_PD2: begin
				if (sts.ar_done) begin
					cmd.tag_res  = 1'b1;
					cmd.tgt_load = 1'b1;
					cmd.tgt_sel  = TG_LEFT;
					ret_d        = RET_PDL;
					state_d      = S_AT_RD;
				end
			end
			S_AT_RD: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = RA_TGT;
				state_d    = S_AT1;
			end
			S_AT1: begin
				cmd.ar_start = 1'b1;
				cmd.ar_op    = AR_RED;
				cmd.ar_src   = SRC_SUM;
				state_d      = S_AT2;
			end
			S_AT2: begin
				if (sts.ar_done) begin
					cmd.cap_a    = 1'b1;
					cmd.ar_start = 1'b1;
					cmd.ar_op    = AR_RED;
					cmd.ar_src   = SRC_PEND;
					state_d      = S_AT3;
				end
			end
			S_AT3: begin
				if (sts.ar_done) begin
					cmd.cap_b    = 1'b1;
					cmd.ar_start = 1'b1;
					cmd.ar_op    = AR_MUL;
					cmd.ar_src   = SRC_TAG;
					state_d      = S_AT4;
				end
			end
			S_AT4: begin
				if (sts.ar_done) begin
					cmd.wr_tag = 1'b1;
					case (ret_q)
						RET_PDL: begin
							cmd.tgt_load = 1'b1;
							cmd.tgt_sel  = TG_RIGHT;
							ret_d        = RET_PDR;
							state_d      = S_AT_RD;
						end
						RET_PDR: state_d = S_PDZ;
						default: state_d = S_POP;
					endcase
				end
			end
			S_PDZ: begin
				cmd.wr_pz = 1'b1;
				state_d   = S_PUSHS;
			end
			S_PUSHS: begin
				if (!sts.is_sum) begin
					cmd.push     = 1'b1;
					cmd.push_sel = PS_SELF;
				end
				state_d = S_PUSHR;
			end
			S_PUSHR: begin
				if (sts.go_right) begin
					cmd.push     = 1'b1;
					cmd.push_sel = PS_RIGHT;
				end
				state_d = S_PUSHL;
			end
			S_PUSHL: begin
				if (sts.go_left) begin
					cmd.push     = 1'b1;
					cmd.push_sel = PS_LEFT;
				end
				state_d = S_POP;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### hdl/lazy_segment_tree_range_add_sum_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum_mod: range add / range sum modulo p
// Lazy segment tree over positions 1..n with a configurable modulus.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its node store clear, one node a cycle
// over all 2^($clog2(MAX_POSITIONS)+1) nodes (2048 at the default), holding
// req.ready low; configuration writes are taken throughout. Each request is
// then handled alone: an add request (command 0) adds the addend, reduced
// mod p, to every position of [left_index, right_index] and returns nothing;
// a sum request (command 1) returns one range_sum. The tree is walked with an
// explicit stack by one shared serial modular unit, so time per request is
// set by that unit and the single read port of the node store, through which
// every node gathered, pulled up or walked through and every tag applied
// must pass, a tag taking a length multiply besides its reductions. Any
// stored value not below the current modulus (after the modulus register
// has been lowered) is reduced bit by bit. A finished sum sits in an output
// register, so the next request is taken while it waits; a second sum waits
// only if the first has not been collected. Write configuration only while
// the block is idle.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_add_sum_mod #(
	parameter int MAX_POSITIONS = lst_pkg::MAX_POSITIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lst_req_if.sink                       req,
	lst_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [lst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lst_pkg::VAL_W-1:0]     cfg_data
);
	import lst_pkg::*;

	lst_cmd_t cmd;
	lst_sts_t sts;
	logic     ready;

	// sequencer: clearing sweep, tree walk, result hand-off
	lst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.ready     (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	lst_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (req.command),
		.left_index  (req.left_index),
		.right_index (req.right_index),
		.addend      (req.addend),
		.out_ready   (res.ready),
		.out_valid   (res.valid),
		.out_sum     (res.range_sum)
	);

	// take a request only when the walker is idle
	assign req.ready = ready;

endmodule

### hdl/lst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_checker: port-level checks of the lazy segment tree
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lst_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [lst_pkg::VAL_W-1:0] res_range_sum
);
	// a stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_range_sum))
		else $error("result changed while stalled");

	// one request at a time: busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a walk is in progress");

	// a new result only appears at the end of a walk
	a_res_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(req_ready))
		else $error("result raised while the block was idle");
endmodule

bind lazy_segment_tree_range_add_sum_mod lst_checker u_lst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_range_sum (res.range_sum)
);
